// File: design/metc_pkg.sv
// ----------------------------------------------------------------------------
// metc_pkg: shared types and constants for the escape-time pixel core
// Payload structs, configuration register map, controller states and the
// command/status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package metc_pkg;

	// Default parameter values
	localparam int METC_MAX_DIM    = 1024;
	localparam int METC_ITER_LIMIT = 1023;
	localparam int METC_FRAC_BITS  = 28;

	// Field widths
	localparam int PIX_W    = 10;
	localparam int CNT_W    = 10;
	localparam int GRAY_W   = 8;
	localparam int COORD_W  = 32;
	localparam int SPAN_W   = COORD_W + 1;
	localparam int PROD_W   = SPAN_W + PIX_W + 1;
	localparam int MAG_W    = PROD_W - 1;
	localparam int ITER_W   = 10;
	localparam int RAD_W    = 3;
	localparam int DIM_CFG_W = 11;

	// Configuration port
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// Register reset values
	localparam logic signed [COORD_W-1:0] RST_RE_MIN = -32'sd536870912;
	localparam logic signed [COORD_W-1:0] RST_RE_MAX = 32'sd268435456;
	localparam logic signed [COORD_W-1:0] RST_IM_MIN = -32'sd402653184;
	localparam logic signed [COORD_W-1:0] RST_IM_MAX = 32'sd402653184;
	localparam logic [ITER_W-1:0]    RST_MAX_ITER   = 10'd255;
	localparam logic [RAD_W-1:0]     RST_RADIUS     = 3'd2;
	localparam logic [DIM_CFG_W-1:0] RST_WIDTH      = 11'd400;
	localparam logic [DIM_CFG_W-1:0] RST_HEIGHT     = 11'd400;

	// Register indexes (byte address / 4)
	typedef enum logic [2:0] {
		REG_RE_MIN,
		REG_RE_MAX,
		REG_IM_MIN,
		REG_IM_MAX,
		REG_MAX_ITER,
		REG_RADIUS,
		REG_WIDTH,
		REG_HEIGHT
	} metc_reg_e;

	// Payloads
	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} metc_in_t;

	typedef struct packed {
		logic [CNT_W-1:0]  iteration_count;
		logic [GRAY_W-1:0] gray_level;
	} metc_out_t;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic signed [COORD_W-1:0] re_min;
		logic signed [COORD_W-1:0] re_max;
		logic signed [COORD_W-1:0] im_min;
		logic signed [COORD_W-1:0] im_max;
		logic [ITER_W-1:0]         max_iterations;
		logic [RAD_W-1:0]          escape_radius;
		logic [DIM_CFG_W-1:0]      image_width;
		logic [DIM_CFG_W-1:0]      image_height;
	} metc_cfg_t;

	// Which operands the shared divider works on
	typedef enum logic [1:0] {
		DIV_RE,
		DIV_IM,
		DIV_GRAY
	} metc_div_sel_e;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_DRE_GO,
		S_DRE_WAIT,
		S_DIM_GO,
		S_DIM_WAIT,
		S_ITER,
		S_GDIV_GO,
		S_GDIV_WAIT,
		S_DONE
	} metc_state_e;

	// Controller to datapath
	typedef struct packed {
		logic          load_pix;
		logic          map_mul;
		logic          div_start;
		metc_div_sel_e div_sel;
		logic          cap_re;
		logic          cap_im;
		logic          iter_init;
		logic          iter_step;
		logic          cap_gray;
		logic          out_load;
	} metc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
		logic iter_stop;
		logic limit_zero;
		logic out_free;
	} metc_sts_t;

endpackage

// File: design/metc_regs.sv
// ----------------------------------------------------------------------------
// metc_regs: configuration register file
// APB-style slave holding the plane bounds, iteration limit, escape radius
// and image dimensions. Zero wait states.
// ----------------------------------------------------------------------------
module metc_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [metc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [metc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [metc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output metc_pkg::metc_cfg_t              cfg
);
	import metc_pkg::*;

	metc_cfg_t cfg_q;
	metc_reg_e idx;
	logic      wr_en;

	assign idx    = metc_reg_e'(paddr[APB_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.re_min         <= RST_RE_MIN;
			cfg_q.re_max         <= RST_RE_MAX;
			cfg_q.im_min         <= RST_IM_MIN;
			cfg_q.im_max         <= RST_IM_MAX;
			cfg_q.max_iterations <= RST_MAX_ITER;
			cfg_q.escape_radius  <= RST_RADIUS;
			cfg_q.image_width    <= RST_WIDTH;
			cfg_q.image_height   <= RST_HEIGHT;
		end else if (wr_en) begin
			case (idx)
				REG_RE_MIN:   cfg_q.re_min         <= $signed(pwdata);
				REG_RE_MAX:   cfg_q.re_max         <= $signed(pwdata);
				REG_IM_MIN:   cfg_q.im_min         <= $signed(pwdata);
				REG_IM_MAX:   cfg_q.im_max         <= $signed(pwdata);
				REG_MAX_ITER: cfg_q.max_iterations <= pwdata[ITER_W-1:0];
				REG_RADIUS:   cfg_q.escape_radius  <= pwdata[RAD_W-1:0];
				REG_WIDTH:    cfg_q.image_width    <= pwdata[DIM_CFG_W-1:0];
				REG_HEIGHT:   cfg_q.image_height   <= pwdata[DIM_CFG_W-1:0];
				default:      cfg_q.re_min         <= cfg_q.re_min;
			endcase
		end
	end

	// read-back
	always_comb begin
		case (idx)
			REG_RE_MIN:   prdata = cfg_q.re_min;
			REG_RE_MAX:   prdata = cfg_q.re_max;
			REG_IM_MIN:   prdata = cfg_q.im_min;
			REG_IM_MAX:   prdata = cfg_q.im_max;
			REG_MAX_ITER: prdata = APB_DATA_W'(cfg_q.max_iterations);
			REG_RADIUS:   prdata = APB_DATA_W'(cfg_q.escape_radius);
			REG_WIDTH:    prdata = APB_DATA_W'(cfg_q.image_width);
			REG_HEIGHT:   prdata = APB_DATA_W'(cfg_q.image_height);
			default:      prdata = '0;
		endcase
	end

endmodule

// File: design/metc_div.sv
// ----------------------------------------------------------------------------
// metc_div: unsigned restoring divider
// One quotient bit per cycle; done pulses once the quotient is ready.
// ----------------------------------------------------------------------------
module metc_div #(
	parameter int DVD_W = 43,
	parameter int DSR_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output logic             done
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DSR_W:0]   shifted;
	logic [DSR_W:0]   diff;
	logic             ge;

	// trial subtraction
	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = shifted >= {1'b0, dsr_q};

	assign quotient = quo_q;
	assign done     = done_q;

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// shift/subtract datapath; the quotient shifts in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

endmodule

// File: design/metc_dp.sv
// ----------------------------------------------------------------------------
// metc_dp: datapath of the escape-time core
// Pixel-to-plane mapping, the complex iteration unit, the shared divider,
// the gray-level scaling and the result register.
// ----------------------------------------------------------------------------
module metc_dp #(
	parameter int MAX_DIM    = metc_pkg::METC_MAX_DIM,
	parameter int ITER_LIMIT = metc_pkg::METC_ITER_LIMIT,
	parameter int FRAC_BITS  = metc_pkg::METC_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  metc_pkg::metc_cfg_t   cfg,
	input  metc_pkg::metc_in_t    pix,
	input  metc_pkg::metc_cmd_t   cmd,
	output metc_pkg::metc_sts_t   sts,
	output logic                  res_valid,
	input  logic                  res_ready,
	output metc_pkg::metc_out_t   res
);
	import metc_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int KW    = $clog2(ITER_LIMIT + 1);
	localparam int GN_W  = KW + GRAY_W;
	localparam int DVD_W = (MAG_W > GN_W) ? MAG_W : GN_W;
	localparam int DSR_W = (DIM_W > KW) ? DIM_W : KW;

	// saturate a wide signed value to the 32-bit coordinate range
	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[COORD_W-1:0];
	endfunction

	// clamped dimensions and iteration limit
	logic [DIM_W-1:0] width_c;
	logic [DIM_W-1:0] height_c;
	logic [KW-1:0]    lim_c;

	always_comb begin
		if (cfg.image_width == '0)
			width_c = DIM_W'(1);
		else if (32'(cfg.image_width) > 32'(MAX_DIM))
			width_c = DIM_W'(MAX_DIM);
		else
			width_c = DIM_W'(cfg.image_width);

		if (cfg.image_height == '0)
			height_c = DIM_W'(1);
		else if (32'(cfg.image_height) > 32'(MAX_DIM))
			height_c = DIM_W'(MAX_DIM);
		else
			height_c = DIM_W'(cfg.image_height);

		if (32'(cfg.max_iterations) > 32'(ITER_LIMIT))
			lim_c = KW'(ITER_LIMIT);
		else
			lim_c = KW'(cfg.max_iterations);
	end

	// pixel capture and span products
	logic [PIX_W-1:0]         px_q;
	logic [PIX_W-1:0]         py_q;
	logic signed [SPAN_W-1:0] span_re;
	logic signed [SPAN_W-1:0] span_im;
	logic signed [PROD_W-1:0] prod_re_c;
	logic signed [PROD_W-1:0] prod_im_c;
	logic signed [PROD_W-1:0] prod_re_q;
	logic signed [PROD_W-1:0] prod_im_q;

	assign span_re = $signed({cfg.re_max[COORD_W-1], cfg.re_max})
	               - $signed({cfg.re_min[COORD_W-1], cfg.re_min});
	assign span_im = $signed({cfg.im_max[COORD_W-1], cfg.im_max})
	               - $signed({cfg.im_min[COORD_W-1], cfg.im_min});
	assign prod_re_c = PROD_W'(span_re) * PROD_W'($signed({1'b0, px_q}));
	assign prod_im_c = PROD_W'(span_im) * PROD_W'($signed({1'b0, py_q}));

	always_ff @(posedge clk) begin
		if (cmd.load_pix) begin
			px_q <= pix.pixel_x;
			py_q <= pix.pixel_y;
		end
		if (cmd.map_mul) begin
			prod_re_q <= prod_re_c;
			prod_im_q <= prod_im_c;
		end
	end

	// magnitudes for the unsigned divider
	logic [PROD_W-1:0] neg_re;
	logic [PROD_W-1:0] neg_im;
	logic [MAG_W-1:0]  mag_re;
	logic [MAG_W-1:0]  mag_im;

	assign neg_re = -prod_re_q;
	assign neg_im = -prod_im_q;
	assign mag_re = prod_re_q[PROD_W-1] ? neg_re[MAG_W-1:0] : prod_re_q[MAG_W-1:0];
	assign mag_im = prod_im_q[PROD_W-1] ? neg_im[MAG_W-1:0] : prod_im_q[MAG_W-1:0];

	// shared divider and its operand select
	logic [KW-1:0]    k_q;
	logic [GN_W-1:0]  gray_num;
	logic [DVD_W-1:0] dvd;
	logic [DSR_W-1:0] dsr;
	logic [DVD_W-1:0] quot;
	logic             div_done;

	// k * 255 as k * 256 - k
	assign gray_num = {k_q, {GRAY_W{1'b0}}} - GN_W'(k_q);

	always_comb begin
		case (cmd.div_sel)
			DIV_RE: begin
				dvd = DVD_W'(mag_re);
				dsr = DSR_W'(width_c);
			end
			DIV_IM: begin
				dvd = DVD_W'(mag_im);
				dsr = DSR_W'(height_c);
			end
			DIV_GRAY: begin
				dvd = DVD_W'(gray_num);
				dsr = DSR_W'(lim_c);
			end
			default: begin
				dvd = DVD_W'(mag_re);
				dsr = DSR_W'(width_c);
			end
		endcase
	end

	metc_div #(
		.DVD_W (DVD_W),
		.DSR_W (DSR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dsr),
		.quotient (quot),
		.done     (div_done)
	);

	// restore the sign (truncation toward zero) and add the lower bound
	logic signed [63:0]        q_pos;
	logic signed [63:0]        q_re;
	logic signed [63:0]        q_im;
	logic signed [COORD_W-1:0] c_re_c;
	logic signed [COORD_W-1:0] c_im_c;
	logic signed [COORD_W-1:0] c_re_q;
	logic signed [COORD_W-1:0] c_im_q;

	assign q_pos  = $signed(64'(quot));
	assign q_re   = prod_re_q[PROD_W-1] ? -q_pos : q_pos;
	assign q_im   = prod_im_q[PROD_W-1] ? -q_pos : q_pos;
	assign c_re_c = sat32(q_re + 64'(cfg.re_min));
	assign c_im_c = sat32(q_im + 64'(cfg.im_min));

	// iteration unit: z = z*z + c, escape test on the current z
	logic signed [COORD_W-1:0] zr_q;
	logic signed [COORD_W-1:0] zi_q;
	logic                      first_q;
	logic signed [63:0]        rr;
	logic signed [63:0]        ii;
	logic signed [63:0]        ri;
	logic signed [COORD_W-1:0] zr_nx;
	logic signed [COORD_W-1:0] zi_nx;
	logic [63:0]               mag_c;
	logic [63:0]               thresh_c;
	logic                      escaped;

	assign rr = 64'(zr_q) * 64'(zr_q);
	assign ii = 64'(zi_q) * 64'(zi_q);
	assign ri = 64'(zr_q) * 64'(zi_q);

	assign zr_nx = sat32(((rr - ii) >>> FRAC_BITS) + 64'(c_re_q));
	assign zi_nx = sat32((ri >>> (FRAC_BITS - 1)) + 64'(c_im_q));

	assign mag_c    = ($unsigned(rr) + $unsigned(ii)) >> FRAC_BITS;
	assign thresh_c = (64'(cfg.escape_radius) * 64'(cfg.escape_radius)) << FRAC_BITS;
	assign escaped  = !(mag_c < thresh_c);

	logic [GRAY_W-1:0] gray_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_re)
			c_re_q <= c_re_c;
		if (cmd.cap_im)
			c_im_q <= c_im_c;
		if (cmd.iter_init) begin
			zr_q    <= '0;
			zi_q    <= '0;
			first_q <= 1'b1;
			k_q     <= '0;
		end else if (cmd.iter_step) begin
			zr_q    <= zr_nx;
			zi_q    <= zi_nx;
			first_q <= 1'b0;
			if (!first_q)
				k_q <= k_q + 1'b1;
		end
		if (cmd.cap_gray)
			gray_q <= quot[GRAY_W-1:0];
	end

	// result register
	metc_out_t res_q;
	logic      res_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.iteration_count <= CNT_W'(k_q);
			res_q.gray_level      <= sts.limit_zero ? '0 : gray_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.out_load)
			res_valid_q <= 1'b1;
		else if (res_ready)
			res_valid_q <= 1'b0;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// status back to the controller
	assign sts.div_done   = div_done;
	assign sts.iter_stop  = !first_q && (escaped || (k_q >= lim_c));
	assign sts.limit_zero = (lim_c == '0);
	assign sts.out_free   = !res_valid_q || res_ready;

endmodule

// File: design/metc_ctrl.sv
// ----------------------------------------------------------------------------
// metc_ctrl: sequencing state machine
// Steps one pixel through mapping, the two axis divisions, the iteration
// loop and the gray-level division, then hands the result to the output.
// ----------------------------------------------------------------------------
module metc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_ready,
	input  metc_pkg::metc_sts_t sts,
	output metc_pkg::metc_cmd_t cmd
);
	import metc_pkg::*;

	metc_state_e state_q;
	metc_state_e state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:      if (pix_valid) state_nx = S_MUL;
			S_MUL:       state_nx = S_DRE_GO;
			S_DRE_GO:    state_nx = S_DRE_WAIT;
			S_DRE_WAIT:  if (sts.div_done) state_nx = S_DIM_GO;
			S_DIM_GO:    state_nx = S_DIM_WAIT;
			S_DIM_WAIT:  if (sts.div_done) state_nx = S_ITER;
			S_ITER: begin
				if (sts.iter_stop)
					state_nx = sts.limit_zero ? S_DONE : S_GDIV_GO;
			end
			S_GDIV_GO:   state_nx = S_GDIV_WAIT;
			S_GDIV_WAIT: if (sts.div_done) state_nx = S_DONE;
			S_DONE:      if (sts.out_free) state_nx = S_IDLE;
			default:     state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		cmd.div_sel = DIV_RE;
		pix_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				pix_ready    = 1'b1;
				cmd.load_pix = pix_valid;
			end
			S_MUL: cmd.map_mul = 1'b1;
			S_DRE_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_RE;
			end
			S_DRE_WAIT: begin
				cmd.div_sel = DIV_RE;
				cmd.cap_re  = sts.div_done;
			end
			S_DIM_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_IM;
			end
			S_DIM_WAIT: begin
				cmd.div_sel   = DIV_IM;
				cmd.cap_im    = sts.div_done;
				cmd.iter_init = sts.div_done;
			end
			S_ITER: cmd.iter_step = !sts.iter_stop;
			S_GDIV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_GRAY;
			end
			S_GDIV_WAIT: begin
				cmd.div_sel  = DIV_GRAY;
				cmd.cap_gray = sts.div_done;
			end
			S_DONE: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// File: design/mandelbrot_escape_time_pixel_core.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_core: escape-time evaluator for one pixel
// Maps a pixel onto the complex plane, iterates z = z*z + c in signed
// fixed point and returns the iteration count and a gray level.
// ----------------------------------------------------------------------------
// One pixel is in flight at a time. The iteration loop runs one complex
// iteration per cycle; each pixel also takes three passes of the shared
// one-bit-per-cycle divider (for the real and imaginary mapping and the
// gray level) and the sequencing states. With a zero iteration limit the
// gray-level division is skipped. The result sits in an output register, so
// the next pixel is accepted while a finished result waits to be taken; a
// second finished result stalls until the first one is transferred.
// Configuration must only be written while no pixel is in progress.
module mandelbrot_escape_time_pixel_core #(
	parameter int MAX_DIM    = metc_pkg::METC_MAX_DIM,
	parameter int ITER_LIMIT = metc_pkg::METC_ITER_LIMIT,
	parameter int FRAC_BITS  = metc_pkg::METC_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// pixel input
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  metc_pkg::metc_in_t               pix,
	// result output
	output logic                             res_valid,
	input  logic                             res_ready,
	output metc_pkg::metc_out_t              res,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [metc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [metc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [metc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import metc_pkg::*;

	metc_cfg_t cfg;
	metc_cmd_t cmd;
	metc_sts_t sts;

	// configuration registers
	metc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	metc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic
	metc_dp #(
		.MAX_DIM    (MAX_DIM),
		.ITER_LIMIT (ITER_LIMIT),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pix       (pix),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

// File: design/metc_checker.sv
// ----------------------------------------------------------------------------
// metc_checker: port-level assertions for the escape-time core
// Watches the pixel and result channels of the top level.
// ----------------------------------------------------------------------------
module metc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                pix_valid,
	input logic                pix_ready,
	input logic                res_valid,
	input logic                res_ready,
	input metc_pkg::metc_out_t res
);
	import metc_pkg::*;

	// a stalled result transfer holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("result changed or dropped while stalled");

	// only one pixel in progress: the core is busy right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready) |=> !pix_ready)
		else $error("pixel accepted while another is in progress");

	// a zero count always maps to black
	a_zero_gray: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res.iteration_count != '0) || (res.gray_level == '0)))
		else $error("non-zero gray level for zero iterations");

	// no result can appear the cycle after a pixel transfer that found none waiting
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready && !res_valid) |=> !res_valid)
		else $error("result appeared straight after a pixel transfer");

endmodule

bind mandelbrot_escape_time_pixel_core metc_checker u_metc_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the escape-time pixel core
// Programs the view over the register port, offers pixels and predicts each
// iteration count and gray level with an in-bench fixed-point model. Results
// are checked in order as they are transferred out. Directed corner cases
// come first, then random views and pixels with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import metc_pkg::*;

	localparam int FRAC = METC_FRAC_BITS;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;
	// Q4.28 constants
	localparam logic [31:0] Q_ONE       = 32'h1000_0000;
	localparam logic [31:0] Q_MINUS_TWO = 32'hE000_0000;
	localparam logic [31:0] Q_MOST_NEG  = 32'h8000_0000;
	localparam logic [31:0] Q_MOST_POS  = 32'h7FFF_FFFF;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_ready;
	metc_in_t              pix       = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	metc_out_t             res;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [APB_ADDR_W-1:0] paddr     = '0;
	logic [APB_DATA_W-1:0] pwdata    = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Bench copy of the view registers
	metc_cfg_t cfg_model = '{
		re_min: RST_RE_MIN, re_max: RST_RE_MAX, im_min: RST_IM_MIN, im_max: RST_IM_MAX,
		max_iterations: RST_MAX_ITER, escape_radius: RST_RADIUS,
		image_width: RST_WIDTH, image_height: RST_HEIGHT
	};

	metc_out_t pending_escapes[$];
	metc_out_t want;
	int        mismatch_cnt   = 0;
	bit        sender_idle_en = 1'b1;
	bit        sink_idle_en   = 1'b1;
	int        sink_hold_req  = 0;
	int        sink_stall_left = 0;

	mandelbrot_escape_time_pixel_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard ceiling on run time
	initial begin
		#40_000_000;
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------
	// Escape-time predictor
	// ------------------------------------------------------------------
	function automatic longint clip_to_word(longint v);
		if (v > WORD_MAX) return WORD_MAX;
		if (v < WORD_MIN) return WORD_MIN;
		return v;
	endfunction

	// c = lo + (hi - lo) * pixel / dim, truncated towards zero, saturated
	function automatic longint map_to_plane(logic signed [31:0] lo, logic signed [31:0] hi,
			logic [PIX_W-1:0] pixel, logic [DIM_CFG_W-1:0] dim);
		longint span, pos, div;
		span = longint'(hi) - longint'(lo);
		pos  = pixel;
		if (dim == 0)
			div = 1;
		else if (dim > METC_MAX_DIM)
			div = METC_MAX_DIM;
		else
			div = dim;
		return clip_to_word(longint'(lo) + (span * pos) / div);
	endfunction

	function automatic metc_out_t predict_escape(metc_in_t p);
		longint      c_re, c_im, zr, zi, rr, ii, ri;
		logic [63:0] sq_re, sq_im, mag, thresh;
		int unsigned k, limit;
		metc_out_t   r;
		c_re   = map_to_plane(cfg_model.re_min, cfg_model.re_max, p.pixel_x,
				cfg_model.image_width);
		c_im   = map_to_plane(cfg_model.im_min, cfg_model.im_max, p.pixel_y,
				cfg_model.image_height);
		limit  = cfg_model.max_iterations;
		if (limit > METC_ITER_LIMIT)
			limit = METC_ITER_LIMIT;
		thresh = 64'(cfg_model.escape_radius) * 64'(cfg_model.escape_radius);
		thresh = thresh << FRAC;
		zr = 0;
		zi = 0;
		k  = 0;
		forever begin
			rr = zr * zr;
			ii = zi * zi;
			ri = zr * zi;
			// arithmetic shift gives the floor of the scaled products
			zr = clip_to_word(((rr - ii) >>> FRAC) + c_re);
			zi = clip_to_word((ri >>> (FRAC - 1)) + c_im);
			sq_re = zr * zr;
			sq_im = zi * zi;
			mag   = (sq_re + sq_im) >> FRAC;
			if (mag >= thresh || k >= limit)
				break;
			k++;
		end
		r.iteration_count = k[CNT_W-1:0];
		r.gray_level      = (limit == 0) ? '0 : GRAY_W'((k * 255) / limit);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Register port
	// ------------------------------------------------------------------
	task automatic write_reg(metc_reg_e idx, logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_RE_MIN:   cfg_model.re_min         = value;
			REG_RE_MAX:   cfg_model.re_max         = value;
			REG_IM_MIN:   cfg_model.im_min         = value;
			REG_IM_MAX:   cfg_model.im_max         = value;
			REG_MAX_ITER: cfg_model.max_iterations = value[ITER_W-1:0];
			REG_RADIUS:   cfg_model.escape_radius  = value[RAD_W-1:0];
			REG_WIDTH:    cfg_model.image_width    = value[DIM_CFG_W-1:0];
			REG_HEIGHT:   cfg_model.image_height   = value[DIM_CFG_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic program_view(logic [31:0] re_lo, logic [31:0] re_hi, logic [31:0] im_lo,
			logic [31:0] im_hi, logic [ITER_W-1:0] iters, logic [RAD_W-1:0] radius,
			logic [DIM_CFG_W-1:0] w, logic [DIM_CFG_W-1:0] h);
		write_reg(REG_RE_MIN, re_lo);
		write_reg(REG_RE_MAX, re_hi);
		write_reg(REG_IM_MIN, im_lo);
		write_reg(REG_IM_MAX, im_hi);
		write_reg(REG_MAX_ITER, 32'(iters));
		write_reg(REG_RADIUS, 32'(radius));
		write_reg(REG_WIDTH, 32'(w));
		write_reg(REG_HEIGHT, 32'(h));
	endtask

	function automatic logic [31:0] extreme_coord();
		case ($urandom_range(0, 2))
			0:       return Q_MOST_NEG;
			1:       return Q_MOST_POS;
			default: return '0;
		endcase
	endfunction

	task automatic program_random_view();
		int                   kind, centre_re, centre_im, half_re, half_im;
		logic [31:0]          re_lo, re_hi, im_lo, im_hi, tmp;
		logic [ITER_W-1:0]    iters;
		logic [RAD_W-1:0]     radius;
		logic [DIM_CFG_W-1:0] w, h;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			// window somewhere over the set, sometimes mirrored
			centre_re = int'($urandom_range(0, 671088640)) - 536870912;
			centre_im = int'($urandom_range(0, 644245094)) - 322122547;
			half_re   = $urandom_range(65536, 536870912);
			half_im   = $urandom_range(65536, 536870912);
			re_lo = centre_re - half_re;
			re_hi = centre_re + half_re;
			im_lo = centre_im - half_im;
			im_hi = centre_im + half_im;
			if ($urandom_range(0, 3) == 0) begin
				tmp = re_lo; re_lo = re_hi; re_hi = tmp;
			end
			if ($urandom_range(0, 3) == 0) begin
				tmp = im_lo; im_lo = im_hi; im_hi = tmp;
			end
		end else if (kind < 9) begin
			re_lo = $urandom;
			re_hi = $urandom;
			im_lo = $urandom;
			im_hi = $urandom;
		end else begin
			re_lo = extreme_coord();
			re_hi = extreme_coord();
			im_lo = extreme_coord();
			im_hi = extreme_coord();
		end
		case ($urandom_range(0, 19))
			0:       iters = '0;
			1:       iters = ITER_W'($urandom_range(100, 255));
			default: iters = ITER_W'($urandom_range(1, 48));
		endcase
		radius = ($urandom_range(0, 9) < 3) ? RAD_W'($urandom) : RST_RADIUS;
		case ($urandom_range(0, 9))
			0:       w = '0;
			1:       w = DIM_CFG_W'($urandom_range(1025, 2047));
			default: w = DIM_CFG_W'($urandom_range(1, 1024));
		endcase
		case ($urandom_range(0, 9))
			0:       h = '0;
			1:       h = DIM_CFG_W'($urandom_range(1025, 2047));
			default: h = DIM_CFG_W'($urandom_range(1, 1024));
		endcase
		program_view(re_lo, re_hi, im_lo, im_hi, iters, radius, w, h);
	endtask

	// ------------------------------------------------------------------
	// Pixel sender
	// ------------------------------------------------------------------
	task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
		int gap;
		@(negedge clk);
		if (sender_idle_en && $urandom_range(0, 3) == 0) begin
			pix_valid = 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(negedge clk);
		end
		pix       = '{pixel_x: x, pixel_y: y};
		pix_valid = 1'b1;
		do @(posedge clk); while (!pix_ready);
		pending_escapes.push_back(predict_escape(pix));
	endtask

	// Mostly inside the image, now and then anywhere in the field range
	function automatic logic [PIX_W-1:0] pick_pixel(logic [DIM_CFG_W-1:0] dim);
		int eff;
		if (dim == 0)
			eff = 1;
		else if (dim > METC_MAX_DIM)
			eff = METC_MAX_DIM;
		else
			eff = dim;
		if ($urandom_range(0, 6) == 0)
			return PIX_W'($urandom);
		return PIX_W'($urandom_range(0, eff - 1));
	endfunction

	task automatic send_random_pixels(int n);
		repeat (n)
			send_pixel(pick_pixel(cfg_model.image_width), pick_pixel(cfg_model.image_height));
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain_results();
		@(negedge clk);
		pix_valid = 1'b0;
		while (pending_escapes.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result sink: random stall bursts plus an optional long hold-off
	// ------------------------------------------------------------------
	initial begin
		forever begin
			@(negedge clk);
			if (sink_hold_req != 0) begin
				sink_stall_left = sink_hold_req;
				sink_hold_req   = 0;
			end
			if (sink_stall_left > 0) begin
				res_ready = 1'b0;
				sink_stall_left--;
			end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
				res_ready       = 1'b0;
				sink_stall_left = $urandom_range(0, 4);
			end else begin
				res_ready = 1'b1;
			end
		end
	end

	// Compare each transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_escapes.size() == 0) begin
				$error("unexpected result: iteration_count %0d gray_level %0d",
						res.iteration_count, res.gray_level);
				mismatch_cnt++;
			end else begin
				want = pending_escapes.pop_front();
				if (res.iteration_count !== want.iteration_count) begin
					$error("iteration_count: expected %0d, actual %0d",
							want.iteration_count, res.iteration_count);
					mismatch_cnt++;
				end
				if (res.gray_level !== want.gray_level) begin
					$error("gray_level: expected %0d, actual %0d",
							want.gray_level, res.gray_level);
					mismatch_cnt++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Registers untouched since reset
	task automatic test_default_view();
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd200, 10'd200);
		send_pixel(10'd399, 10'd0);
		drain_results();
	endtask

	task automatic test_special_cases();
		// single iteration allowed
		program_view(RST_RE_MIN, RST_RE_MAX, RST_IM_MIN, RST_IM_MAX, 10'd1, 3'd2, 11'd400, 11'd400);
		send_pixel(10'd200, 10'd200);
		send_pixel(10'd0, 10'd0);
		drain_results();
		// zero image size acts as one
		program_view(RST_RE_MIN, RST_RE_MAX, RST_IM_MIN, RST_IM_MAX, 10'd32, 3'd2, 11'd0, 11'd0);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1, 10'd1);
		drain_results();
		// oversized image clamps to the largest size
		program_view(RST_RE_MIN, RST_RE_MAX, RST_IM_MIN, RST_IM_MAX, 10'd32, 3'd2, 11'd2047, 11'd1025);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd512, 10'd1023);
		drain_results();
		// pixel past the edge extrapolates and saturates
		program_view(RST_RE_MIN, RST_RE_MAX, RST_IM_MIN, RST_IM_MAX, 10'd32, 3'd2, 11'd3, 11'd5);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd2, 10'd4);
		drain_results();
		// zero iteration limit
		program_view(RST_RE_MIN, RST_RE_MAX, RST_IM_MIN, RST_IM_MAX, 10'd0, 3'd2, 11'd400, 11'd400);
		send_pixel(10'd200, 10'd200);
		send_pixel(10'd0, 10'd0);
		drain_results();
		// zero escape radius stops at once
		program_view(RST_RE_MIN, RST_RE_MAX, RST_IM_MIN, RST_IM_MAX, 10'd32, 3'd0, 11'd400, 11'd400);
		send_pixel(10'd200, 10'd200);
		drain_results();
		// widest radius, highest limit
		program_view(RST_RE_MIN, RST_RE_MAX, RST_IM_MIN, RST_IM_MAX, 10'd1023, 3'd7, 11'd400, 11'd400);
		send_pixel(10'd200, 10'd200);
		send_pixel(10'd0, 10'd0);
		drain_results();
		// inverted bounds on both axes
		program_view(Q_ONE, Q_MINUS_TWO, RST_IM_MAX, RST_IM_MIN, 10'd40, 3'd2, 11'd400, 11'd400);
		send_pixel(10'd0, 10'd200);
		send_pixel(10'd399, 10'd399);
		drain_results();
		// full coordinate range, spans overflow the word
		program_view(Q_MOST_NEG, Q_MOST_POS, Q_MOST_NEG, Q_MOST_POS, 10'd16, 3'd2, 11'd1024, 11'd1024);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd512, 10'd512);
		drain_results();
	endtask

	task automatic test_random_views();
		repeat (10) begin
			program_random_view();
			send_random_pixels(105);
			drain_results();
		end
	endtask

	// Sink holds off long enough for the core to fill and stall its input
	task automatic test_output_backpressure();
		program_view(RST_RE_MIN, RST_RE_MAX, RST_IM_MIN, RST_IM_MAX, 10'd8, 3'd2, 11'd400, 11'd400);
		sink_hold_req = 3000;
		send_random_pixels(40);
		drain_results();
	endtask

	// Back-to-back transfers with no idling on either side
	task automatic test_steady_stream();
		sender_idle_en = 1'b0;
		sink_idle_en   = 1'b0;
		repeat (2) begin
			program_random_view();
			send_random_pixels(100);
			drain_results();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_default_view();
		test_special_cases();
		test_random_views();
		test_output_backpressure();
		test_steady_stream();
		// room for any stray result to show up
		repeat (1200) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: filelist.f
design/metc_pkg.sv
design/metc_regs.sv
design/metc_div.sv
design/metc_dp.sv
design/metc_ctrl.sv
design/mandelbrot_escape_time_pixel_core.sv
design/metc_checker.sv
tb/tb_top.sv
